FILE: rtl/core/ncc_pkg.sv
`timescale 1ns / 1ps

package ncc_pkg;

   localparam int MAX_CLUSTERS_DEF = 16;
   localparam int MAX_DIMS_DEF     = 64;

   localparam int CMD_W   = 1;
   localparam int CIDX_W  = 4;
   localparam int DIM_W   = 6;
   localparam int VAL_W   = 16;
   localparam int CSR_W   = 5;
   localparam int WIN_W   = 4;
   localparam int DIST_W  = 38;
   localparam int COUNT_W = 20;
   localparam int TOTAL_W = 60;

   localparam logic [CMD_W-1:0]   CMD_LOAD   = 1'b0;
   localparam logic [CMD_W-1:0]   CMD_SAMPLE = 1'b1;
   localparam logic [CSR_W-1:0]   CSR_RESET  = 5'd4;

   localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_SEARCH,
      ST_SWAIT,
      ST_ACCUM,
      ST_DIV,
      ST_EMIT
   } ncc_state_type;

   typedef struct packed {
      logic mac_go;
      logic read_go;
      logic clear;
   } ncc_dist_cmd_type;

   typedef struct packed {
      logic busy;
      logic rd_valid;
   } ncc_dist_stat_type;

endpackage

FILE: rtl/core/ncc_ifs.sv
`timescale 1ns / 1ps

interface ncc_req_if;
   logic                              valid;
   logic                              ready;
   logic [ncc_pkg::CMD_W-1:0]         command;
   logic [ncc_pkg::CIDX_W-1:0]        centroid_index;
   logic [ncc_pkg::DIM_W-1:0]         dim_index;
   logic signed [ncc_pkg::VAL_W-1:0]  element_value;
   logic                              last_element;
   logic                              last_sample;

   modport source (output valid, command, centroid_index, dim_index, element_value,
                   last_element, last_sample, input ready);
   modport sink   (input valid, command, centroid_index, dim_index, element_value,
                   last_element, last_sample, output ready);
endinterface

interface ncc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ncc_pkg::WIN_W-1:0]     winner;
   logic [ncc_pkg::DIST_W-1:0]    min_distance;
   logic [ncc_pkg::COUNT_W-1:0]   sample_count;
   logic [ncc_pkg::DIST_W-1:0]    mean_error;
   logic                          set_end;

   modport source (output valid, winner, min_distance, sample_count, mean_error, set_end,
                   input ready);
   modport sink   (input valid, winner, min_distance, sample_count, mean_error, set_end,
                   output ready);
endinterface

interface ncc_csr_if;
   logic                        valid;
   logic                        ready;
   logic [ncc_pkg::CSR_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/ncc_ram.sv
`timescale 1ns / 1ps

module ncc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/ncc_dist.sv
`timescale 1ns / 1ps

module ncc_dist #(
   parameter int MAX_CLUSTERS = ncc_pkg::MAX_CLUSTERS_DEF,
   parameter int MAX_DIMS     = ncc_pkg::MAX_DIMS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ncc_pkg::ncc_dist_cmd_type             cmd,
   input  logic [$clog2(MAX_CLUSTERS)-1:0]       idx,
   input  logic [ncc_pkg::DIM_W-1:0]             dim,
   input  logic signed [ncc_pkg::VAL_W-1:0]      sample,
   input  logic                                  ld_we,
   input  logic [ncc_pkg::CIDX_W-1:0]            ld_cidx,
   input  logic [ncc_pkg::DIM_W-1:0]             ld_didx,
   input  logic [ncc_pkg::VAL_W-1:0]             ld_data,
   output ncc_pkg::ncc_dist_stat_type            stat,
   output logic [$clog2(MAX_CLUSTERS)-1:0]       rd_idx,
   output logic [ncc_pkg::DIST_W-1:0]            rd_data
);

   localparam int IW    = $clog2(MAX_CLUSTERS);
   localparam int CDEP  = MAX_CLUSTERS * MAX_DIMS;
   localparam int AW    = (CDEP > 1) ? $clog2(CDEP) : 1;
   localparam int DW    = ncc_pkg::DIST_W;
   localparam int VW    = ncc_pkg::VAL_W;
   localparam int PW    = 2 * VW;

   logic [AW-1:0]           c_raddr;
   logic [AW-1:0]           c_waddr;
   logic [VW-1:0]           c_rdata;
   logic [DW-1:0]           pd_rdata;
   logic                    pd_we;
   logic [DW-1:0]           pd_wdata;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_mac_ff, s1_mac_in;
   logic [IW-1:0]           s1_idx_ff, s1_idx_in;
   logic                    s2_valid_ff, s2_valid_in;
   logic [IW-1:0]           s2_idx_ff, s2_idx_in;
   logic [VW-1:0]           s2_abs_ff, s2_abs_in;
   logic [DW-1:0]           s2_acc_ff, s2_acc_in;
   logic                    s3_valid_ff, s3_valid_in;
   logic [IW-1:0]           s3_idx_ff, s3_idx_in;
   logic [PW-1:0]           s3_prod_ff, s3_prod_in;
   logic [DW-1:0]           s3_acc_ff, s3_acc_in;
   logic [MAX_CLUSTERS-1:0] pdv_ff, pdv_in;

   logic signed [VW:0]      diff;
   logic [VW:0]             diff_mag;
   logic [DW-1:0]           pd_masked;
   logic [DW:0]             sum;

   assign c_raddr = AW'(idx) * AW'(MAX_DIMS) + AW'(dim);
   assign c_waddr = AW'(ld_cidx) * AW'(MAX_DIMS) + AW'(ld_didx);

   ncc_ram #(.WIDTH(VW), .DEPTH(CDEP)) u_centroids (
      .clock (clock),
      .we    (ld_we),
      .waddr (c_waddr),
      .wdata (ld_data),
      .raddr (c_raddr),
      .rdata (c_rdata)
   );

   ncc_ram #(.WIDTH(DW), .DEPTH(MAX_CLUSTERS)) u_partials (
      .clock (clock),
      .we    (pd_we),
      .waddr (s3_idx_ff),
      .wdata (pd_wdata),
      .raddr (idx),
      .rdata (pd_rdata)
   );

   always_comb begin
      // An entry that has not been written since the last clear reads as zero.
      pd_masked   = pdv_ff[s1_idx_ff] ? pd_rdata : '0;
      diff        = $signed({sample[VW-1], sample}) - $signed({c_rdata[VW-1], c_rdata});
      diff_mag    = diff[VW] ? (VW+1)'(-diff) : diff;

      s1_valid_in = cmd.mac_go | cmd.read_go;
      s1_mac_in   = cmd.mac_go;
      s1_idx_in   = idx;

      s2_valid_in = s1_valid_ff & s1_mac_ff;
      s2_idx_in   = s1_idx_ff;
      s2_abs_in   = diff_mag[VW-1:0];
      s2_acc_in   = pd_masked;

      s3_valid_in = s2_valid_ff;
      s3_idx_in   = s2_idx_ff;
      s3_prod_in  = s2_abs_ff * s2_abs_ff;
      s3_acc_in   = s2_acc_ff;

      sum         = {1'b0, s3_acc_ff} + (DW+1)'(s3_prod_ff);
      pd_wdata    = (sum > (DW+1)'(ncc_pkg::DIST_MAX)) ? ncc_pkg::DIST_MAX : sum[DW-1:0];
      pd_we       = s3_valid_ff;

      pdv_in      = pdv_ff;
      if (cmd.clear) begin
         pdv_in = '0;
      end else if (s3_valid_ff) begin
         pdv_in[s3_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         pdv_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         pdv_ff      <= pdv_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_mac_ff  <= s1_mac_in;
      s1_idx_ff  <= s1_idx_in;
      s2_idx_ff  <= s2_idx_in;
      s2_abs_ff  <= s2_abs_in;
      s2_acc_ff  <= s2_acc_in;
      s3_idx_ff  <= s3_idx_in;
      s3_prod_ff <= s3_prod_in;
      s3_acc_ff  <= s3_acc_in;
   end

   assign stat.busy     = s1_valid_ff | s2_valid_ff | s3_valid_ff;
   assign stat.rd_valid = s1_valid_ff & ~s1_mac_ff;
   assign rd_idx        = s1_idx_ff;
   assign rd_data       = pd_masked;

endmodule

FILE: rtl/core/ncc_div.sv
`timescale 1ns / 1ps

module ncc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ncc_pkg::TOTAL_W-1:0]   dividend,
   input  logic [ncc_pkg::COUNT_W-1:0]   divisor,
   output logic                          done,
   output logic [ncc_pkg::TOTAL_W-1:0]   quotient
);

   localparam int TW    = ncc_pkg::TOTAL_W;
   localparam int CW    = ncc_pkg::COUNT_W;
   localparam int STEPW = $clog2(TW);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [STEPW-1:0] step_ff, step_in;
   logic [CW-1:0]    rem_ff, rem_in;
   logic [TW-1:0]    quo_ff, quo_in;
   logic [CW-1:0]    dvs_ff, dvs_in;
   logic [CW:0]      rem_sh;
   logic             fits;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[TW-1]};
      fits    = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // One restoring step: shift in the next dividend bit, subtract if it fits.
         rem_in  = fits ? CW'(rem_sh - {1'b0, dvs_ff}) : rem_sh[CW-1:0];
         quo_in  = {quo_ff[TW-2:0], fits};
         step_in = step_ff + STEPW'(1);
         if (step_ff == STEPW'(TW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/core/nearest_centroid_classifier_core.sv
`timescale 1ns / 1ps
// Nearest-centroid classifier. Requests arrive on req_bus: a load request writes one
// centroid element, and a sample request adds one element of the sample vector to the
// running squared distances of the N active centroids (N set by the one register on
// csr_bus, reset value 4). A shared subtract, square and accumulate unit takes one
// centroid per cycle, and the block stays busy with a sample element until all N have
// drained from it. On the last element of a vector the N partial distances are scanned
// for the minimum and one response is placed on rsp_bus; when the request also closes
// the data set, a bit-serial divider forms the mean squared error. req_bus.ready is high
// only while the block is idle. The response sits in an output register until taken;
// the block returns to idle and keeps taking requests, but waits before it can emit the
// next response while the receiver stalls. csr_bus is always ready; the user must see
// that it is written only while the block is idle, which the block itself does not enforce.
// Reset clears the sequencer, the register (to 4), the partial distances, the running
// total and the sample count; the centroid table holds nothing defined until loaded.
module nearest_centroid_classifier_core #(
   parameter int MAX_CLUSTERS = ncc_pkg::MAX_CLUSTERS_DEF,
   parameter int MAX_DIMS     = ncc_pkg::MAX_DIMS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   ncc_req_if.sink      req_bus,
   ncc_rsp_if.source    rsp_bus,
   ncc_csr_if.sink      csr_bus
);

   localparam int IW = $clog2(MAX_CLUSTERS);
   localparam int NW = $clog2(MAX_CLUSTERS + 1);
   localparam int DW = ncc_pkg::DIST_W;
   localparam int TW = ncc_pkg::TOTAL_W;
   localparam int KW = ncc_pkg::COUNT_W;

   ncc_pkg::ncc_state_type          state_ff, state_in;
   logic [ncc_pkg::CSR_W-1:0]       csr_ff, csr_in;
   logic [NW-1:0]                   n_ff, n_in;
   logic [IW-1:0]                   c_ff, c_in;
   logic [ncc_pkg::DIM_W-1:0]       dim_ff, dim_in;
   logic signed [ncc_pkg::VAL_W-1:0] val_ff, val_in;
   logic                            last_el_ff, last_el_in;
   logic                            last_set_ff, last_set_in;
   logic [DW-1:0]                   best_d_ff, best_d_in;
   logic [IW-1:0]                   best_i_ff, best_i_in;
   logic [TW-1:0]                   total_ff, total_in;
   logic [KW-1:0]                   count_ff, count_in;
   logic [DW-1:0]                   mean_ff, mean_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ncc_pkg::WIN_W-1:0]       winner_ff, winner_in;
   logic [DW-1:0]                   min_dist_ff, min_dist_in;
   logic [KW-1:0]                   count_out_ff, count_out_in;
   logic [DW-1:0]                   mean_out_ff, mean_out_in;
   logic                            set_end_ff, set_end_in;

   ncc_pkg::ncc_dist_cmd_type       dist_cmd;
   ncc_pkg::ncc_dist_stat_type      dist_stat;
   logic [IW-1:0]                   rd_idx;
   logic [DW-1:0]                   rd_data;

   logic                            req_ready;
   logic                            accept;
   logic                            dim_ok;
   logic                            ld_we;
   logic [NW-1:0]                   n_act;
   logic [IW-1:0]                   last_c;
   logic                            out_free;
   logic [TW:0]                     total_sum;
   logic [KW-1:0]                   count_next;
   logic [TW-1:0]                   total_next;
   logic                            div_start;
   logic                            div_done;
   logic [TW-1:0]                   quotient;

   assign req_ready = (state_ff == ncc_pkg::ST_IDLE);
   assign accept    = req_bus.valid & req_ready;
   assign dim_ok    = int'(req_bus.dim_index) < MAX_DIMS;
   assign ld_we     = accept & (req_bus.command == ncc_pkg::CMD_LOAD) & dim_ok
                      & (int'(req_bus.centroid_index) < MAX_CLUSTERS);
   assign last_c    = IW'(n_ff - NW'(1));
   assign out_free  = ~rsp_valid_ff | rsp_bus.ready;

   always_comb begin
      if (csr_ff == '0) begin
         n_act = NW'(1);
      end else if (int'(csr_ff) > MAX_CLUSTERS) begin
         n_act = NW'(MAX_CLUSTERS);
      end else begin
         n_act = NW'(csr_ff);
      end
   end

   ncc_dist #(.MAX_CLUSTERS(MAX_CLUSTERS), .MAX_DIMS(MAX_DIMS)) u_dist (
      .clock   (clock),
      .reset   (reset),
      .cmd     (dist_cmd),
      .idx     (c_ff),
      .dim     (dim_ff),
      .sample  (val_ff),
      .ld_we   (ld_we),
      .ld_cidx (req_bus.centroid_index),
      .ld_didx (req_bus.dim_index),
      .ld_data (req_bus.element_value),
      .stat    (dist_stat),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   ncc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_next),
      .divisor  (count_next),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in  = state_ff;
      c_in      = c_ff;
      dist_cmd  = '0;
      div_start = 1'b0;
      case (state_ff)
         ncc_pkg::ST_IDLE: begin
            if (accept && req_bus.command == ncc_pkg::CMD_SAMPLE) begin
               c_in = '0;
               if (dim_ok) begin
                  state_in = ncc_pkg::ST_MAC;
               end else if (req_bus.last_element) begin
                  state_in = ncc_pkg::ST_SEARCH;
               end
            end
         end
         ncc_pkg::ST_MAC: begin
            dist_cmd.mac_go = 1'b1;
            if (c_ff == last_c) begin
               state_in = ncc_pkg::ST_DRAIN;
            end else begin
               c_in = c_ff + IW'(1);
            end
         end
         ncc_pkg::ST_DRAIN: begin
            if (!dist_stat.busy) begin
               c_in     = '0;
               state_in = last_el_ff ? ncc_pkg::ST_SEARCH : ncc_pkg::ST_IDLE;
            end
         end
         ncc_pkg::ST_SEARCH: begin
            dist_cmd.read_go = 1'b1;
            if (c_ff == last_c) begin
               state_in = ncc_pkg::ST_SWAIT;
            end else begin
               c_in = c_ff + IW'(1);
            end
         end
         ncc_pkg::ST_SWAIT: begin
            if (!dist_stat.busy) begin
               state_in = ncc_pkg::ST_ACCUM;
            end
         end
         ncc_pkg::ST_ACCUM: begin
            dist_cmd.clear = 1'b1;
            div_start      = last_set_ff;
            state_in       = last_set_ff ? ncc_pkg::ST_DIV : ncc_pkg::ST_EMIT;
         end
         ncc_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = ncc_pkg::ST_EMIT;
            end
         end
         ncc_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = ncc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ncc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      total_sum  = {1'b0, total_ff} + (TW+1)'(best_d_ff);
      total_next = (total_sum > (TW+1)'(ncc_pkg::TOTAL_MAX)) ? ncc_pkg::TOTAL_MAX
                                                             : total_sum[TW-1:0];
      count_next = (count_ff == ncc_pkg::COUNT_MAX) ? count_ff : count_ff + KW'(1);

      csr_in       = csr_ff;
      n_in         = n_ff;
      dim_in       = dim_ff;
      val_in       = val_ff;
      last_el_in   = last_el_ff;
      last_set_in  = last_set_ff;
      best_d_in    = best_d_ff;
      best_i_in    = best_i_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      mean_in      = mean_ff;
      rsp_valid_in = rsp_valid_ff;
      winner_in    = winner_ff;
      min_dist_in  = min_dist_ff;
      count_out_in = count_out_ff;
      mean_out_in  = mean_out_ff;
      set_end_in   = set_end_ff;

      if (csr_bus.valid) begin
         csr_in = csr_bus.data;
      end

      if (accept && req_bus.command == ncc_pkg::CMD_SAMPLE) begin
         n_in        = n_act;
         dim_in      = req_bus.dim_index;
         val_in      = req_bus.element_value;
         last_el_in  = req_bus.last_element;
         last_set_in = req_bus.last_sample;
      end

      // Strict less-than keeps the lower index on a tie.
      if (dist_stat.rd_valid && (rd_idx == '0 || rd_data < best_d_ff)) begin
         best_d_in = rd_data;
         best_i_in = rd_idx;
      end

      if (state_ff == ncc_pkg::ST_ACCUM) begin
         total_in = total_next;
         count_in = count_next;
      end

      if (state_ff == ncc_pkg::ST_DIV && div_done) begin
         mean_in = (quotient > TW'(ncc_pkg::DIST_MAX)) ? ncc_pkg::DIST_MAX
                                                      : quotient[DW-1:0];
      end

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ncc_pkg::ST_EMIT && out_free) begin
         rsp_valid_in = 1'b1;
         winner_in    = ncc_pkg::WIN_W'(best_i_ff);
         min_dist_in  = best_d_ff;
         count_out_in = count_ff;
         mean_out_in  = last_set_ff ? mean_ff : '0;
         set_end_in   = last_set_ff;
         if (last_set_ff) begin
            total_in = '0;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ncc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= ncc_pkg::CSR_RESET;
         c_ff         <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         csr_ff       <= csr_in;
         c_ff         <= c_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      dim_ff       <= dim_in;
      val_ff       <= val_in;
      last_el_ff   <= last_el_in;
      last_set_ff  <= last_set_in;
      best_d_ff    <= best_d_in;
      best_i_ff    <= best_i_in;
      mean_ff      <= mean_in;
      winner_ff    <= winner_in;
      min_dist_ff  <= min_dist_in;
      count_out_ff <= count_out_in;
      mean_out_ff  <= mean_out_in;
      set_end_ff   <= set_end_in;
   end

   assign req_bus.ready        = req_ready;
   assign csr_bus.ready        = 1'b1;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.winner       = winner_ff;
   assign rsp_bus.min_distance = min_dist_ff;
   assign rsp_bus.sample_count = count_out_ff;
   assign rsp_bus.mean_error   = mean_out_ff;
   assign rsp_bus.set_end      = set_end_ff;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ncc_pkg::*;

   localparam int NUM_CENTROIDS  = MAX_CLUSTERS_DEF;
   localparam int NUM_DIMS       = MAX_DIMS_DEF;
   localparam int SETTLE_CYCLES  = 160;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_REQUESTS = 110;
   localparam int NUM_PHASES     = 8;
   localparam int FAR_DIM        = 42;

   typedef struct {
      logic [CMD_W-1:0]         command;
      logic [CIDX_W-1:0]        centroid_index;
      logic [DIM_W-1:0]         dim_index;
      logic signed [VAL_W-1:0]  element_value;
      logic                     last_element;
      logic                     last_sample;
   } request_type;

   typedef struct {
      logic [WIN_W-1:0]    winner;
      logic [DIST_W-1:0]   min_distance;
      logic [COUNT_W-1:0]  sample_count;
      logic [DIST_W-1:0]   mean_error;
      logic                set_end;
   } classification_type;

   class classification_board_type;
      logic signed [VAL_W-1:0] centroid_table [NUM_CENTROIDS][NUM_DIMS];
      logic [DIST_W-1:0]       partial_distance [NUM_CENTROIDS];
      logic [TOTAL_W-1:0]      total_error;
      logic [COUNT_W-1:0]      samples_seen;
      logic [CSR_W-1:0]        clusters_reg;
      classification_type      pending[$];
      int                      mismatch_count;

      function new();
         foreach (partial_distance[c]) partial_distance[c] = '0;
         total_error    = '0;
         samples_seen   = '0;
         clusters_reg   = CSR_RESET;
         mismatch_count = 0;
      endfunction

      function void set_clusters(logic [CSR_W-1:0] value);
         clusters_reg = value;
      endfunction

      function void take_request(request_type r);
         int                 active;
         int                 best_index;
         longint signed      diff;
         longint unsigned    square;
         logic [39:0]        sum;
         logic [DIST_W-1:0]  best;
         logic [TOTAL_W-1:0] headroom;
         logic [TOTAL_W-1:0] mean;
         classification_type res;
         if (r.command == CMD_LOAD) begin
            centroid_table[r.centroid_index][r.dim_index] = r.element_value;
            return;
         end
         if (clusters_reg == 0) begin
            active = 1;
         end else if (clusters_reg > NUM_CENTROIDS) begin
            active = NUM_CENTROIDS;
         end else begin
            active = clusters_reg;
         end
         for (int c = 0; c < active; c++) begin
            diff   = longint'(r.element_value) - longint'(centroid_table[c][r.dim_index]);
            square = diff * diff;
            sum    = partial_distance[c] + square;
            partial_distance[c] = (sum > DIST_MAX) ? DIST_MAX : sum[DIST_W-1:0];
         end
         if (!r.last_element) return;
         best       = partial_distance[0];
         best_index = 0;
         for (int c = 1; c < active; c++) begin
            if (partial_distance[c] < best) begin
               best       = partial_distance[c];
               best_index = c;
            end
         end
         foreach (partial_distance[c]) partial_distance[c] = '0;
         if (samples_seen != COUNT_MAX) samples_seen++;
         headroom    = TOTAL_MAX - total_error;
         total_error = (headroom < best) ? TOTAL_MAX : total_error + best;
         res.winner       = best_index[WIN_W-1:0];
         res.min_distance = best;
         res.sample_count = samples_seen;
         res.mean_error   = '0;
         res.set_end      = 1'b0;
         if (r.last_sample) begin
            mean           = total_error / samples_seen;
            res.mean_error = (mean > DIST_MAX) ? DIST_MAX : mean[DIST_W-1:0];
            res.set_end    = 1'b1;
            total_error    = '0;
            samples_seen   = '0;
         end
         pending.push_back(res);
      endfunction

      function void check_classification(classification_type got);
         classification_type want;
         if (pending.size() == 0) begin
            $error("unexpected classification: winner %0d, min_distance %0d",
                   got.winner, got.min_distance);
            mismatch_count++;
            return;
         end
         want = pending.pop_front();
         if (got.winner !== want.winner) begin
            $error("winner: expected %0d, actual %0d", want.winner, got.winner);
            mismatch_count++;
         end
         if (got.min_distance !== want.min_distance) begin
            $error("min_distance: expected %0d, actual %0d", want.min_distance,
                   got.min_distance);
            mismatch_count++;
         end
         if (got.sample_count !== want.sample_count) begin
            $error("sample_count: expected %0d, actual %0d", want.sample_count,
                   got.sample_count);
            mismatch_count++;
         end
         if (got.mean_error !== want.mean_error) begin
            $error("mean_error: expected %0d, actual %0d", want.mean_error, got.mean_error);
            mismatch_count++;
         end
         if (got.set_end !== want.set_end) begin
            $error("set_end: expected %0d, actual %0d", want.set_end, got.set_end);
            mismatch_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   ncc_req_if req_bus ();
   ncc_rsp_if rsp_bus ();
   ncc_csr_if csr_bus ();

   classification_board_type board;
   bit                       written [NUM_CENTROIDS][NUM_DIMS];
   int                       usable_dims[$];
   int                       requests_sent;
   int                       hold_request;
   bit                       req_steady;
   bit                       rsp_steady;

   nearest_centroid_classifier_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #2 clock = ~clock;

   function automatic int pick_gap(bit steady);
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic signed [VAL_W-1:0] pick_value();
      logic signed [VAL_W-1:0] extremes [4];
      extremes = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1};
      if ($urandom_range(0, 9) == 0) return extremes[$urandom_range(0, 3)];
      return VAL_W'($urandom);
   endfunction

   function automatic request_type load_req(int cidx, int dim,
                                            logic signed [VAL_W-1:0] value, bit flags);
      request_type r;
      r.command        = CMD_LOAD;
      r.centroid_index = cidx[CIDX_W-1:0];
      r.dim_index      = dim[DIM_W-1:0];
      r.element_value  = value;
      r.last_element   = flags;
      r.last_sample    = flags;
      return r;
   endfunction

   function automatic request_type sample_req(int dim, logic signed [VAL_W-1:0] value,
                                              bit last_el, bit last_set);
      request_type r;
      r.command        = CMD_SAMPLE;
      r.centroid_index = CIDX_W'($urandom);
      r.dim_index      = dim[DIM_W-1:0];
      r.element_value  = value;
      r.last_element   = last_el;
      r.last_sample    = last_set;
      return r;
   endfunction

   task automatic issue(request_type r);
      int gap;
      bit complete;
      gap = pick_gap(req_steady);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.command        <= r.command;
      req_bus.centroid_index <= r.centroid_index;
      req_bus.dim_index      <= r.dim_index;
      req_bus.element_value  <= r.element_value;
      req_bus.last_element   <= r.last_element;
      req_bus.last_sample    <= r.last_sample;
      req_bus.valid          <= 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.take_request(r);
      requests_sent++;
      if (r.command == CMD_LOAD && !written[r.centroid_index][r.dim_index]) begin
         written[r.centroid_index][r.dim_index] = 1'b1;
         complete = 1'b1;
         for (int c = 0; c < NUM_CENTROIDS; c++) begin
            if (!written[c][r.dim_index]) complete = 1'b0;
         end
         if (complete) usable_dims.push_back(r.dim_index);
      end
   endtask

   // Holds back further requests until every classification has arrived and the
   // block has had time to finish any element that produces no response.
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_clusters(logic [CSR_W-1:0] value);
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      board.set_clusters(value);
   endtask

   task automatic fill_column(int dim, bit far);
      logic signed [VAL_W-1:0] value;
      value = '0;
      for (int c = 0; c < NUM_CENTROIDS; c++) begin
         if (far) begin
            value = 16'sh8000;
         end else if (c == 0 || $urandom_range(0, 4) != 0) begin
            value = pick_value();
         end
         issue(load_req(c, dim, value, $urandom_range(0, 1)));
      end
   endtask

   // Vectors longer than the table run along the far column so that the
   // distances saturate.
   task automatic send_vector(int length);
      int dim;
      bit far;
      bit closing;
      far = (length > NUM_DIMS);
      for (int i = 0; i < length; i++) begin
         closing = (i == length - 1);
         if (!far && $urandom_range(0, 19) == 0) begin
            issue(load_req($urandom_range(0, NUM_CENTROIDS - 1), $urandom_range(0, NUM_DIMS - 1),
                           pick_value(), $urandom_range(0, 1)));
         end
         dim = far ? FAR_DIM : usable_dims[$urandom_range(0, usable_dims.size() - 1)];
         issue(sample_req(dim, far ? 16'sh7FFF : pick_value(), closing,
                          closing ? ($urandom_range(0, 4) == 0) : ($urandom_range(0, 9) == 0)));
      end
   endtask

   initial begin
      int phase_clusters [NUM_PHASES];
      int phase_end;
      int pick;
      int extra_dim;
      board          = new();
      requests_sent  = 0;
      hold_request   = 0;
      req_steady     = 1'b0;
      rsp_steady     = 1'b0;
      phase_clusters = '{16, 31, 2, 17, 1, 9, $urandom_range(0, 31), 16};
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.command        <= CMD_LOAD;
      req_bus.centroid_index <= '0;
      req_bus.dim_index      <= '0;
      req_bus.element_value  <= '0;
      req_bus.last_element   <= 1'b0;
      req_bus.last_sample    <= 1'b0;
      csr_bus.valid          <= 1'b0;
      csr_bus.data           <= CSR_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      issue(load_req(0, 0, 16'sh8000, 1'b0));
      issue(load_req(1, 0, 16'sh7FFF, 1'b0));
      issue(load_req(2, 0, 16'sh0000, 1'b0));
      issue(load_req(3, 0, -16'sd1, 1'b1));
      issue(load_req(0, 63, 16'sh7FFF, 1'b0));
      issue(load_req(1, 63, 16'sh7FFF, 1'b0));
      issue(load_req(2, 63, 16'sh8000, 1'b0));
      issue(load_req(3, 63, -16'sd20000, 1'b0));
      issue(sample_req(0, 16'sh7FFF, 1'b1, 1'b0));
      issue(sample_req(0, 16'sh8000, 1'b0, 1'b0));
      issue(sample_req(63, 16'sh7FFF, 1'b1, 1'b1));
      // Centroids 0 and 1 are equal along this vector, so the lower index wins.
      issue(sample_req(63, 16'sh7000, 1'b0, 1'b1));
      issue(sample_req(63, 16'sh7F00, 1'b1, 1'b0));
      issue(sample_req(63, 16'sh8000, 1'b1, 1'b1));
      issue(sample_req(0, 16'sh1234, 1'b0, 1'b0));
      quiesce();
      write_clusters(5'd1);
      issue(sample_req(63, -16'sd300, 1'b1, 1'b0));
      quiesce();
      write_clusters(5'd0);
      issue(sample_req(63, 16'sh0100, 1'b0, 1'b0));
      quiesce();
      write_clusters(5'd4);
      issue(sample_req(0, 16'sh0100, 1'b1, 1'b1));

      for (int p = 0; p < NUM_PHASES; p++) begin
         quiesce();
         write_clusters(phase_clusters[p][CSR_W-1:0]);
         req_steady = (p == 3) || ($urandom_range(0, 3) == 0);
         rsp_steady = (p == 3) || ($urandom_range(0, 3) == 0);
         if (p == 0) begin
            fill_column(0, 1'b0);
            fill_column(NUM_DIMS - 1, 1'b0);
            fill_column(FAR_DIM, 1'b1);
         end
         if (p == 0 || $urandom_range(0, 1) == 0) begin
            do extra_dim = $urandom_range(1, NUM_DIMS - 2); while (extra_dim == FAR_DIM);
            fill_column(extra_dim, 1'b0);
         end
         if (p == 2) hold_request = HOLD_CYCLES;
         phase_end = requests_sent + PHASE_REQUESTS;
         while (requests_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
               issue(load_req($urandom_range(0, NUM_CENTROIDS - 1),
                              $urandom_range(0, NUM_DIMS - 1), pick_value(),
                              $urandom_range(0, 1)));
            end else if (pick < 15) begin
               send_vector($urandom_range(66, 70));
            end else if (pick < 40) begin
               send_vector($urandom_range(5, 12));
            end else begin
               send_vector($urandom_range(1, 4));
            end
         end
      end
      quiesce();

      if (board.mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      classification_type got;
      int                 stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            stall        = hold_request;
            hold_request = 0;
         end else begin
            stall = pick_gap(rsp_steady);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
         got.winner       = rsp_bus.winner;
         got.min_distance = rsp_bus.min_distance;
         got.sample_count = rsp_bus.sample_count;
         got.mean_error   = rsp_bus.mean_error;
         got.set_end      = rsp_bus.set_end;
         board.check_classification(got);
      end
   end

   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
